>>> hdl/rdc_pkg.sv
package rdc_pkg;

  // Fixed point and time widths
  localparam int FRAC_BITS = 16;
  localparam int TIME_W    = 32;
  localparam int DRIFT_W   = 29;
  localparam int PPM_W     = 12;
  localparam int MAXERR_W  = 31;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  // Shared multiplier operand width
  localparam int MUL_W = 32;

  // Divider geometry: numerator up to |x| * 1e6 << FRAC_BITS, divisor up to
  // SCALE plus the largest drift.
  localparam int NUM_W       = 68;
  localparam int DEN_W       = 36;
  localparam int SHORT_STEPS = 35;
  localparam int LONG_STEPS  = NUM_W;
  localparam int CNT_W       = $clog2(LONG_STEPS + 1);

  localparam logic [19:0]      MILLION = 20'd1000000;
  localparam logic [DEN_W-1:0] SCALE   = DEN_W'(64'd1000000 << FRAC_BITS);

  // Clamp limits in fixed point
  localparam int STEP_W = PPM_W + FRAC_BITS;
  localparam int QM_W   = SHORT_STEPS;
  localparam int QADJ_W = SHORT_STEPS + 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DRIFT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERV = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERROR  = 2'd3;

  typedef enum logic [1:0] {
    KIND_CORRECT = 2'd0,
    KIND_TO_RAW  = 2'd1,
    KIND_SYNC    = 2'd2,
    KIND_RESET   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STAT_NONE   = 3'd0,
    STAT_ACCEPT = 3'd1,
    STAT_SOON   = 3'd2,
    STAT_LARGE  = 3'd3,
    STAT_BOTH   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_CORR = 2'd0,
    OP_MAP  = 2'd1,
    OP_CAL  = 2'd2
  } op_t;

  typedef struct packed {
    logic start;
    logic long_mode;
  } div_cmd_t;

endpackage

>>> hdl/rtc_drift_compensator.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: kind; tdata: raw_seconds, given_seconds
// m_*       out  m_tvalid/m_tready  tdata: time_result .. calib_status
// cfg_*     in   cfg_we             cfg_addr register index, cfg_wdata value
//
// One request at a time; s_tready is high only while the sequencer is idle.
// Once synced, kinds 0 to 2 use the shared divider, which retires one quotient
// bit per cycle (35 steps for a correction or a raw mapping, 68 for the drift
// update of a sync that recalibrates). Never-synced kinds 0 and 1, and kind 3,
// skip the divider.
// Reset (rst, synchronous) restores register defaults, zero drift, never
// synced. The result register lets the next request in while m_tready is low.
module rtc_drift_compensator (
  input  logic                          clk,
  input  logic                          rst,
  // slave side
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [63:0]                   s_tdata,   // [31:0] raw_seconds, [63:32] given_seconds
  input  logic [1:0]                    s_tuser,   // [1:0] kind
  // master side
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [127:0]                  m_tdata,   // [31:0] time_result, [60:32] drift_q16,
                                                   // [92:61] last_sync_seconds,
                                                   // [124:93] sync_error_seconds,
                                                   // [127:125] calib_status
  // configuration
  input  logic                          cfg_we,
  input  logic [rdc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [rdc_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int TW = rdc_pkg::TIME_W;
  localparam int DW = rdc_pkg::DRIFT_W;
  localparam int NDW = rdc_pkg::DRIFT_W + 1;

  typedef enum logic [13:0] {
    ST_IDLE      = 14'h0001,
    ST_START     = 14'h0002,
    ST_DIV_GO    = 14'h0004,
    ST_DIV_WAIT  = 14'h0008,
    ST_FIX_CORR  = 14'h0010,
    ST_CHECK     = 14'h0020,
    ST_JUDGE     = 14'h0040,
    ST_LIMIT     = 14'h0080,
    ST_FIX_MAP   = 14'h0100,
    ST_MAP2      = 14'h0200,
    ST_FIX_CAL   = 14'h0400,
    ST_CAL_ADD   = 14'h0800,
    ST_CAL_CLAMP = 14'h1000,
    ST_DONE      = 14'h2000
  } state_t;

  state_t state;

  // configuration registers
  logic [rdc_pkg::PPM_W-1:0]    max_drift;
  logic [rdc_pkg::PPM_W-1:0]    max_step;
  logic [TW-1:0]                min_interval;
  logic [rdc_pkg::MAXERR_W-1:0] max_error;

  // persistent estimate
  logic signed [DW-1:0] drift;
  logic [TW-1:0]        last;

  // request and work registers
  rdc_pkg::kind_t       kind;
  logic [TW-1:0]        raw;
  logic [TW-1:0]        given;
  logic [TW-1:0]        tc;
  logic [TW-1:0]        tres;
  logic signed [TW-1:0] err;
  logic [TW-1:0]        errm;
  logic [TW-1:0]        elapsed;
  logic                 soon;
  rdc_pkg::status_t     status;
  rdc_pkg::op_t         op;
  logic [rdc_pkg::QADJ_W-1:0] qadj;
  logic [rdc_pkg::STEP_W-1:0] mag;
  logic signed [NDW-1:0]      nd;

  // shared units
  logic                          mul_en;
  logic [rdc_pkg::MUL_W-1:0]     mul_a;
  logic [rdc_pkg::MUL_W-1:0]     mul_b;
  logic [2*rdc_pkg::MUL_W-1:0]   prod;
  rdc_pkg::div_cmd_t             div_cmd;
  logic [rdc_pkg::NUM_W-1:0]     div_num;
  logic [rdc_pkg::DEN_W-1:0]     div_den;
  logic                          div_done;
  logic [rdc_pkg::NUM_W-1:0]     quo;
  logic [rdc_pkg::DEN_W-1:0]     rem;

  // elapsed since sync for the correction, with magnitudes of its operands
  logic [TW-1:0]   e_diff;
  logic            e_neg;
  logic [TW-1:0]   e_mag;
  logic            d_neg;
  logic [DW-1:0]   d_mag;
  // target minus last sync for the raw mapping (33 bit, never wraps)
  logic [TW:0]     m_diff;
  logic            m_neg;
  logic [TW:0]     m_mag;

  logic [TW-1:0]              tc_new;
  logic                       err_big;
  logic [rdc_pkg::STEP_W-1:0] step_lim;
  logic [rdc_pkg::STEP_W-1:0] ceil_lim;
  logic signed [NDW-1:0]      ceil_s;
  logic signed [NDW-1:0]      drift_x;
  logic signed [NDW-1:0]      mag_x;
  logic [rdc_pkg::DEN_W-1:0]  drift_den;
  logic [rdc_pkg::QADJ_W-1:0] last_x;
  logic [rdc_pkg::QADJ_W-1:0] map_sum;

  assign s_tready = (state == ST_IDLE);

  assign e_diff = raw - last;
  assign e_neg  = e_diff[TW-1];
  assign e_mag  = e_neg ? (TW'(0) - e_diff) : e_diff;
  assign d_neg  = drift[DW-1];
  assign d_mag  = d_neg ? (DW'(0) - drift) : drift;
  assign m_diff = {1'b0, given} - {1'b0, last};
  assign m_neg  = m_diff[TW];
  assign m_mag  = m_neg ? ((TW+1)'(0) - m_diff) : m_diff;

  // correction is truncated toward zero, so its sign follows drift * elapsed
  assign tc_new = (e_neg != d_neg) ? (raw + quo[TW-1:0]) : (raw - quo[TW-1:0]);

  assign err_big  = errm > {1'b0, max_error};
  assign step_lim = {max_step, {rdc_pkg::FRAC_BITS{1'b0}}};
  assign ceil_lim = {max_drift, {rdc_pkg::FRAC_BITS{1'b0}}};
  assign ceil_s   = $signed({{(NDW-rdc_pkg::STEP_W){1'b0}}, ceil_lim});
  assign drift_x  = {drift[DW-1], drift};
  assign mag_x    = $signed({{(NDW-rdc_pkg::STEP_W){1'b0}}, mag});
  assign drift_den = {{(rdc_pkg::DEN_W-DW){drift[DW-1]}}, drift};
  assign last_x   = {{(rdc_pkg::QADJ_W-TW){1'b0}}, last};
  assign map_sum  = last_x + qadj;

  // multiplier operands: drift * elapsed, or a time magnitude * 1e6
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      ST_START: begin
        mul_en = 1'b1;
        if (kind == rdc_pkg::KIND_TO_RAW) begin
          mul_a = m_mag[TW-1:0];
          mul_b = rdc_pkg::MUL_W'(rdc_pkg::MILLION);
        end else begin
          mul_a = rdc_pkg::MUL_W'(d_mag);
          mul_b = e_mag;
        end
      end
      ST_LIMIT: begin
        mul_en = 1'b1;
        mul_a  = errm;
        mul_b  = rdc_pkg::MUL_W'(rdc_pkg::MILLION);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // divider operands; SCALE = 1e6 << FRAC_BITS is folded in as a shift
  always_comb begin
    div_cmd.start     = (state == ST_DIV_GO);
    div_cmd.long_mode = (op == rdc_pkg::OP_CAL);
    if (op == rdc_pkg::OP_CORR) begin
      div_num = rdc_pkg::NUM_W'(prod);
    end else begin
      div_num = {prod[rdc_pkg::NUM_W-rdc_pkg::FRAC_BITS-1:0], {rdc_pkg::FRAC_BITS{1'b0}}};
    end
    case (op)
      rdc_pkg::OP_CORR: div_den = rdc_pkg::SCALE;
      rdc_pkg::OP_MAP:  div_den = rdc_pkg::SCALE - drift_den;
      rdc_pkg::OP_CAL:  div_den = {{(rdc_pkg::DEN_W-TW){1'b0}}, elapsed};
      default:          div_den = rdc_pkg::SCALE;
    endcase
  end

  rdc_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  rdc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .cmd  (div_cmd),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (quo),
    .rem  (rem)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_drift    <= rdc_pkg::PPM_W'(3000);
      max_step     <= rdc_pkg::PPM_W'(100);
      min_interval <= TW'(3600);
      max_error    <= rdc_pkg::MAXERR_W'(300);
    end else if (cfg_we) begin
      case (cfg_addr)
        rdc_pkg::CFG_MAX_DRIFT:  max_drift    <= cfg_wdata[rdc_pkg::PPM_W-1:0];
        rdc_pkg::CFG_MAX_STEP:   max_step     <= cfg_wdata[rdc_pkg::PPM_W-1:0];
        rdc_pkg::CFG_MIN_INTERV: min_interval <= cfg_wdata[TW-1:0];
        rdc_pkg::CFG_MAX_ERROR:  max_error    <= cfg_wdata[rdc_pkg::MAXERR_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      drift    <= '0;
      last     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // ST_DONE reloads the result register itself
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            kind   <= rdc_pkg::kind_t'(s_tuser);
            raw    <= s_tdata[TW-1:0];
            given  <= s_tdata[2*TW-1:TW];
            tres   <= '0;
            err    <= '0;
            status <= rdc_pkg::STAT_NONE;
            state  <= ST_START;
          end
        end
        ST_START: begin
          case (kind)
            rdc_pkg::KIND_CORRECT, rdc_pkg::KIND_SYNC: begin
              if (last == '0) begin
                // never synced: time passes unchanged
                tc <= raw;
                if (kind == rdc_pkg::KIND_SYNC) begin
                  state <= ST_CHECK;
                end else begin
                  tres  <= raw;
                  state <= ST_DONE;
                end
              end else begin
                op    <= rdc_pkg::OP_CORR;
                state <= ST_DIV_GO;
              end
            end
            rdc_pkg::KIND_TO_RAW: begin
              if (last == '0) begin
                tres  <= given;
                state <= ST_DONE;
              end else begin
                op    <= rdc_pkg::OP_MAP;
                state <= ST_DIV_GO;
              end
            end
            default: begin
              drift <= '0;
              last  <= '0;
              state <= ST_DONE;
            end
          endcase
        end
        ST_DIV_GO: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            case (op)
              rdc_pkg::OP_CORR: state <= ST_FIX_CORR;
              rdc_pkg::OP_MAP:  state <= ST_FIX_MAP;
              default:          state <= ST_FIX_CAL;
            endcase
          end
        end
        ST_FIX_CORR: begin
          tc <= tc_new;
          if (kind == rdc_pkg::KIND_SYNC) begin
            state <= ST_CHECK;
          end else begin
            tres  <= tc_new;
            state <= ST_DONE;
          end
        end
        ST_CHECK: begin
          err     <= $signed(tc - given);
          elapsed <= given - last;
          state   <= ST_JUDGE;
        end
        ST_JUDGE: begin
          errm  <= err[TW-1] ? (TW'(0) - err) : err;
          // zero elapsed is always too soon
          soon  <= (elapsed == '0) || (elapsed < min_interval);
          state <= ST_LIMIT;
        end
        ST_LIMIT: begin
          if (!soon && !err_big) begin
            op    <= rdc_pkg::OP_CAL;
            state <= ST_DIV_GO;
          end else begin
            if (soon && err_big) begin
              status <= rdc_pkg::STAT_BOTH;
            end else if (soon) begin
              status <= rdc_pkg::STAT_SOON;
            end else begin
              status <= rdc_pkg::STAT_LARGE;
            end
            // a rejected sync still moves the sync point
            last  <= given;
            state <= ST_DONE;
          end
        end
        ST_FIX_MAP: begin
          // negative side rounds the magnitude up, giving the floor
          if (m_neg) begin
            qadj <= {1'b0, quo[rdc_pkg::QM_W-1:0]} + rdc_pkg::QADJ_W'(rem != '0);
          end else begin
            qadj <= {1'b0, quo[rdc_pkg::QM_W-1:0]};
          end
          state <= ST_MAP2;
        end
        ST_MAP2: begin
          if (!m_neg) begin
            tres <= (map_sum[rdc_pkg::QADJ_W-1:TW] != '0) ? '1 : map_sum[TW-1:0];
          end else begin
            tres <= (qadj > last_x) ? '0 : (last - qadj[TW-1:0]);
          end
          state <= ST_DONE;
        end
        ST_FIX_CAL: begin
          if ((quo[rdc_pkg::NUM_W-1:rdc_pkg::STEP_W] != '0)
              || (quo[rdc_pkg::STEP_W-1:0] > step_lim)) begin
            mag <= step_lim;
          end else begin
            mag <= quo[rdc_pkg::STEP_W-1:0];
          end
          state <= ST_CAL_ADD;
        end
        ST_CAL_ADD: begin
          nd    <= err[TW-1] ? (drift_x - mag_x) : (drift_x + mag_x);
          state <= ST_CAL_CLAMP;
        end
        ST_CAL_CLAMP: begin
          if (nd > ceil_s) begin
            drift <= ceil_s[DW-1:0];
          end else if (nd < (NDW'(0) - ceil_s)) begin
            drift <= DW'(0) - ceil_s[DW-1:0];
          end else begin
            drift <= nd[DW-1:0];
          end
          last   <= given;
          status <= rdc_pkg::STAT_ACCEPT;
          state  <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {status, err, last, drift, tres};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/rdc_mul.sv
module rdc_mul (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rdc_pkg::MUL_W-1:0]   a,
  input  logic [rdc_pkg::MUL_W-1:0]   b,
  output logic [2*rdc_pkg::MUL_W-1:0] p
);

  // registered product, valid the cycle after en
  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

>>> hdl/rdc_div.sv
module rdc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  rdc_pkg::div_cmd_t         cmd,
  input  logic [rdc_pkg::NUM_W-1:0] num,
  input  logic [rdc_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [rdc_pkg::NUM_W-1:0] quo,
  output logic [rdc_pkg::DEN_W-1:0] rem
);

  logic [rdc_pkg::DEN_W-1:0] den_q;
  logic [rdc_pkg::NUM_W-1:0] shreg;
  logic [rdc_pkg::CNT_W-1:0] cnt;
  logic                      busy;
  logic [rdc_pkg::DEN_W:0]   trial;
  logic [rdc_pkg::DEN_W:0]   trial_sub;
  logic                      fits;

  // restoring division, one quotient bit per cycle
  assign trial     = {rem, shreg[rdc_pkg::NUM_W-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign fits      = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // pulse with the last quotient bit
      done <= !cmd.start && busy && (cnt == rdc_pkg::CNT_W'(1));
      if (cmd.start) begin
        busy  <= 1'b1;
        den_q <= den;
        quo   <= '0;
        if (cmd.long_mode) begin
          rem   <= '0;
          shreg <= num;
          cnt   <= rdc_pkg::CNT_W'(rdc_pkg::LONG_STEPS);
        end else begin
          // top bits are known to stay below the divisor: preload them
          rem   <= rdc_pkg::DEN_W'(num[rdc_pkg::NUM_W-1:rdc_pkg::SHORT_STEPS]);
          shreg <= {num[rdc_pkg::SHORT_STEPS-1:0],
                    {(rdc_pkg::NUM_W-rdc_pkg::SHORT_STEPS){1'b0}}};
          cnt   <= rdc_pkg::CNT_W'(rdc_pkg::SHORT_STEPS);
        end
      end else if (busy) begin
        rem   <= fits ? trial_sub[rdc_pkg::DEN_W-1:0] : trial[rdc_pkg::DEN_W-1:0];
        quo   <= {quo[rdc_pkg::NUM_W-2:0], fits};
        shreg <= {shreg[rdc_pkg::NUM_W-2:0], 1'b0};
        cnt   <= cnt - 1'b1;
        if (cnt == rdc_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
